// ===== hw/rtl/stbs_pkg.sv =====
// Package for the speed and turn beacon scheduler.
// Holds register indexes, constants, the control word and the microcode ROM.
// Used by every module in hw/rtl; depends on nothing.
package stbs_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned COURSE_W = 9;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned DIV_A_W = 38;
  localparam int unsigned DIV_B_W = 20;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned PC_W = 3;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [13:0] SCALE_MS_Q4 = 14'd16000;
  localparam logic [8:0] HALF_TURN = 9'd180;
  localparam logic [8:0] FULL_TURN = 9'd360;

  localparam logic [2:0] REG_LOW_SPEED = 3'd0;
  localparam logic [2:0] REG_HIGH_SPEED = 3'd1;
  localparam logic [2:0] REG_SLOW_RATE = 3'd2;
  localparam logic [2:0] REG_FAST_RATE = 3'd3;
  localparam logic [2:0] REG_TURN_MIN = 3'd4;
  localparam logic [2:0] REG_TURN_GAIN = 3'd5;
  localparam logic [2:0] REG_MIN_TURN_TIME = 3'd6;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_TURN = 2'd1;
  localparam logic [1:0] CAUSE_INTERVAL = 2'd2;

  localparam logic [PC_W-1:0] ST_IDLE = 3'd0;
  localparam logic [PC_W-1:0] ST_MUL_A = 3'd1;
  localparam logic [PC_W-1:0] ST_MUL_B = 3'd2;
  localparam logic [PC_W-1:0] ST_DIV_INIT = 3'd3;
  localparam logic [PC_W-1:0] ST_DIV_STEP = 3'd4;
  localparam logic [PC_W-1:0] ST_EVAL_A = 3'd5;
  localparam logic [PC_W-1:0] ST_EVAL_B = 3'd6;
  localparam logic [PC_W-1:0] ST_OUT = 3'd7;

  typedef struct packed {
    logic [7:0] low_speed_kmph;
    logic [7:0] high_speed_kmph;
    logic [15:0] slow_rate_s;
    logic [15:0] fast_rate_s;
    logic [7:0] turn_min_deg;
    logic [15:0] turn_gain;
    logic [15:0] min_turn_time_s;
  } cfg_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic ld_in;
    logic mul_a;
    logic mul_b;
    logic div_init;
    logic div_step;
    logic eval_a;
    logic eval_b;
    logic out_ld;
    cond_t cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic div_more;
    logic out_busy;
  } seq_stat_t;

  function automatic ctl_t rom_word(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    w.cond = COND_NEVER;
    case (pc)
      ST_IDLE: begin
        w.ld_in = 1'b1;
        w.cond = COND_NO_INPUT;
        w.target = ST_IDLE;
      end
      ST_MUL_A: w.mul_a = 1'b1;
      ST_MUL_B: w.mul_b = 1'b1;
      ST_DIV_INIT: w.div_init = 1'b1;
      ST_DIV_STEP: begin
        w.div_step = 1'b1;
        w.cond = COND_DIV_MORE;
        w.target = ST_DIV_STEP;
      end
      ST_EVAL_A: w.eval_a = 1'b1;
      ST_EVAL_B: w.eval_b = 1'b1;
      ST_OUT: begin
        w.out_ld = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.target = ST_OUT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/speed_turn_beacon_scheduler_top.sv =====
// Speed and turn adaptive beacon scheduler: one position fix in, one word out.
// The block works on one fix at a time, in this order when the output is not stalled:
// four setup steps, 38 steps of the one-bit-per-cycle divider that forms the
// interval and turn limit from the speed, then two evaluation steps and one
// output step. The next fix is accepted in the cycle after the output word is
// loaded. Configuration registers sit on a 32-bit APB-style port at 4-byte steps.
// Depends on stbs_pkg, stbs_cfg, stbs_div and stbs_useq.
module speed_turn_beacon_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_fix_valid,
  input  logic                        in_button_pressed,
  input  logic [15:0]                 in_speed_q4,
  input  logic [8:0]                  in_course_deg,
  input  logic [31:0]                 in_now_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_manual_send,
  output logic                        out_beacon_send,
  output logic [1:0]                  out_beacon_cause,
  output logic [31:0]                 out_interval_ms,
  output logic [15:0]                 out_turn_limit_deg,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stbs_pkg::ADDR_W-1:0] paddr,
  input  logic [stbs_pkg::DATA_W-1:0] pwdata,
  output logic [stbs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import stbs_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  seq_stat_t stat;

  logic fix_r, btn_r;
  logic [SPEED_W-1:0] q_r;
  logic [COURSE_W-1:0] course_r, prev_course_r;
  logic [TIME_W-1:0] now_r, last_beacon_r;

  logic [23:0] p1_r;
  logic [25:0] slow_ms_r, fast_ms_r, turn_ms_r;
  logic [DIV_A_W-1:0] prod_r;
  logic [DIV_A_W-1:0] quot_a;
  logic [DIV_B_W-1:0] quot_b;
  logic div_more;

  logic [TIME_W-1:0] interval_r, elapsed_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [COURSE_W-1:0] delta_r;

  logic [TIME_W-1:0] interval_nxt;
  logic [LIMIT_W-1:0] limit_nxt;
  logic [COURSE_W-1:0] d0, delta_nxt;
  logic [DIV_B_W:0] lim_sum;

  logic res_btn_r;
  logic [1:0] res_cause_r;
  logic [TIME_W-1:0] res_interval_r;
  logic [LIMIT_W-1:0] res_limit_r;
  logic turn_hit, ivl_hit;

  logic out_valid_r, out_busy, out_load, in_take;

  stbs_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign stat.in_valid = in_valid;
  assign stat.div_more = div_more;
  assign stat.out_busy = out_busy;

  stbs_useq u_seq (.clk(clk), .rst_n(rst_n), .stat(stat), .ctl(ctl));

  stbs_div u_div (
    .clk(clk), .rst_n(rst_n), .init(ctl.div_init), .step(ctl.div_step),
    .divisor(q_r), .dividend_a(prod_r), .dividend_b({cfg.turn_gain, 4'd0}),
    .quot_a(quot_a), .quot_b(quot_b), .more(div_more)
  );

  assign in_stall = !ctl.ld_in;
  assign in_take = in_valid && ctl.ld_in;
  assign out_busy = out_valid_r && out_stall;
  assign out_load = ctl.out_ld && !out_busy;

  always_ff @(posedge clk) begin
    if (in_take) begin
      fix_r <= in_fix_valid;
      btn_r <= in_button_pressed;
      q_r <= in_speed_q4;
      course_r <= in_course_deg;
      now_r <= in_now_ms;
    end
    if (ctl.mul_a) begin
      p1_r <= 24'(cfg.fast_rate_s) * 24'(cfg.high_speed_kmph);
      slow_ms_r <= 26'(cfg.slow_rate_s) * 26'(MS_PER_S);
      fast_ms_r <= 26'(cfg.fast_rate_s) * 26'(MS_PER_S);
    end
    if (ctl.mul_b) begin
      prod_r <= DIV_A_W'(p1_r) * DIV_A_W'(SCALE_MS_Q4);
      turn_ms_r <= 26'(cfg.min_turn_time_s) * 26'(MS_PER_S);
    end
  end

  always_comb begin
    if (q_r < {4'd0, cfg.low_speed_kmph, 4'd0}) begin
      interval_nxt = TIME_W'(slow_ms_r);
    end else if (q_r > {4'd0, cfg.high_speed_kmph, 4'd0}) begin
      interval_nxt = TIME_W'(fast_ms_r);
    end else if (q_r == '0 || quot_a[DIV_A_W-1:TIME_W] != '0) begin
      interval_nxt = '1;
    end else begin
      interval_nxt = quot_a[TIME_W-1:0];
    end
    lim_sum = {1'b0, quot_b} + (DIV_B_W+1)'(cfg.turn_min_deg);
    if (q_r == '0 || lim_sum[DIV_B_W:LIMIT_W] != '0) begin
      limit_nxt = '1;
    end else begin
      limit_nxt = lim_sum[LIMIT_W-1:0];
    end
    d0 = (prev_course_r > course_r) ? prev_course_r - course_r
                                    : course_r - prev_course_r;
    if (d0 > HALF_TURN) begin
      delta_nxt = (d0 > FULL_TURN) ? d0 - FULL_TURN : FULL_TURN - d0;
    end else begin
      delta_nxt = d0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval_a) begin
      interval_r <= interval_nxt;
      limit_r <= limit_nxt;
      delta_r <= delta_nxt;
      elapsed_r <= now_r - last_beacon_r;
    end
  end

  assign turn_hit = ({7'd0, delta_r} > limit_r) && (elapsed_r > TIME_W'(turn_ms_r));
  assign ivl_hit = elapsed_r > interval_r;

  always_ff @(posedge clk) begin
    if (ctl.eval_b) begin
      res_btn_r <= fix_r && btn_r;
      res_interval_r <= fix_r ? interval_r : '0;
      res_limit_r <= fix_r ? limit_r : '0;
      if (!fix_r) begin
        res_cause_r <= CAUSE_NONE;
      end else if (turn_hit) begin
        res_cause_r <= CAUSE_TURN;
      end else if (ivl_hit) begin
        res_cause_r <= CAUSE_INTERVAL;
      end else begin
        res_cause_r <= CAUSE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_course_r <= '0;
      last_beacon_r <= '0;
    end else if (ctl.eval_b && fix_r) begin
      prev_course_r <= course_r;
      if (turn_hit || ivl_hit) begin
        last_beacon_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_manual_send <= res_btn_r;
      out_beacon_send <= res_cause_r != CAUSE_NONE;
      out_beacon_cause <= res_cause_r;
      out_interval_ms <= res_interval_r;
      out_turn_limit_deg <= res_limit_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/stbs_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on stbs_pkg for the register indexes and the cfg_t bundle.
module stbs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stbs_pkg::ADDR_W-1:0] paddr,
  input  logic [stbs_pkg::DATA_W-1:0] pwdata,
  output logic [stbs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output stbs_pkg::cfg_t              cfg
);
  import stbs_pkg::*;

  cfg_t cfg_r;
  logic [2:0] idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_speed_kmph <= 8'd10;
      cfg_r.high_speed_kmph <= 8'd100;
      cfg_r.slow_rate_s <= 16'd1200;
      cfg_r.fast_rate_s <= 16'd60;
      cfg_r.turn_min_deg <= 8'd25;
      cfg_r.turn_gain <= 16'd255;
      cfg_r.min_turn_time_s <= 16'd15;
    end else if (wr_en) begin
      case (idx)
        REG_LOW_SPEED: cfg_r.low_speed_kmph <= pwdata[7:0];
        REG_HIGH_SPEED: cfg_r.high_speed_kmph <= pwdata[7:0];
        REG_SLOW_RATE: cfg_r.slow_rate_s <= pwdata[15:0];
        REG_FAST_RATE: cfg_r.fast_rate_s <= pwdata[15:0];
        REG_TURN_MIN: cfg_r.turn_min_deg <= pwdata[7:0];
        REG_TURN_GAIN: cfg_r.turn_gain <= pwdata[15:0];
        REG_MIN_TURN_TIME: cfg_r.min_turn_time_s <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOW_SPEED: prdata = {24'd0, cfg_r.low_speed_kmph};
      REG_HIGH_SPEED: prdata = {24'd0, cfg_r.high_speed_kmph};
      REG_SLOW_RATE: prdata = {16'd0, cfg_r.slow_rate_s};
      REG_FAST_RATE: prdata = {16'd0, cfg_r.fast_rate_s};
      REG_TURN_MIN: prdata = {24'd0, cfg_r.turn_min_deg};
      REG_TURN_GAIN: prdata = {16'd0, cfg_r.turn_gain};
      REG_MIN_TURN_TIME: prdata = {16'd0, cfg_r.min_turn_time_s};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/stbs_div.sv =====
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle while step is high.
// Lane B joins for its last steps only. Depends on stbs_pkg for widths.
module stbs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         init,
  input  logic                         step,
  input  logic [stbs_pkg::SPEED_W-1:0] divisor,
  input  logic [stbs_pkg::DIV_A_W-1:0] dividend_a,
  input  logic [stbs_pkg::DIV_B_W-1:0] dividend_b,
  output logic [stbs_pkg::DIV_A_W-1:0] quot_a,
  output logic [stbs_pkg::DIV_B_W-1:0] quot_b,
  output logic                         more
);
  import stbs_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LastCnt = DIV_CNT_W'(DIV_A_W - 1);
  localparam logic [DIV_CNT_W-1:0] StartB = DIV_CNT_W'(DIV_A_W - DIV_B_W);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SPEED_W-1:0] rem_a_r, rem_b_r;
  logic [DIV_A_W-1:0] qa_r;
  logic [DIV_B_W-1:0] qb_r;
  logic [SPEED_W:0] sh_a, sh_b, dv;
  logic ge_a, ge_b;

  assign dv = {1'b0, divisor};
  assign sh_a = {rem_a_r, qa_r[DIV_A_W-1]};
  assign sh_b = {rem_b_r, qb_r[DIV_B_W-1]};
  assign ge_a = sh_a >= dv;
  assign ge_b = sh_b >= dv;
  assign more = cnt_r != LastCnt;
  assign quot_a = qa_r;
  assign quot_b = qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (init) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      rem_a_r <= '0;
      rem_b_r <= '0;
      qa_r <= dividend_a;
      qb_r <= dividend_b;
    end else if (step) begin
      rem_a_r <= ge_a ? SPEED_W'(sh_a - dv) : sh_a[SPEED_W-1:0];
      qa_r <= {qa_r[DIV_A_W-2:0], ge_a};
      if (cnt_r >= StartB) begin
        rem_b_r <= ge_b ? SPEED_W'(sh_b - dv) : sh_b[SPEED_W-1:0];
        qb_r <= {qb_r[DIV_B_W-2:0], ge_b};
      end
    end
  end

endmodule

// ===== hw/rtl/stbs_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on stbs_pkg for the control word and the ROM contents.
module stbs_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  stbs_pkg::seq_stat_t stat,
  output stbs_pkg::ctl_t      ctl
);
  import stbs_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic jump;

  assign ctl = rom_word(pc_r);

  always_comb begin
    case (ctl.cond)
      COND_NEVER: jump = 1'b0;
      COND_NO_INPUT: jump = !stat.in_valid;
      COND_DIV_MORE: jump = stat.div_more;
      COND_OUT_BUSY: jump = stat.out_busy;
      default: jump = 1'b0;
    endcase
    pc_nxt = jump ? ctl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hw/rtl/stbs_chk.sv =====
// Port-level checker for the beacon scheduler, bound to the top level.
// Depends on stbs_pkg for the beacon cause codes.
module stbs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_manual_send,
  input logic        out_beacon_send,
  input logic [1:0]  out_beacon_cause,
  input logic [31:0] out_interval_ms,
  input logic [15:0] out_turn_limit_deg,
  input logic        pready
);
  import stbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beacon_cause)
      && $stable(out_interval_ms) && $stable(out_turn_limit_deg)
      && $stable(out_manual_send))
    else $error("Stalled output word changed.");

  a_send_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beacon_send == (out_beacon_cause != CAUSE_NONE))
      && (out_beacon_cause == CAUSE_NONE || out_beacon_cause == CAUSE_TURN
          || out_beacon_cause == CAUSE_INTERVAL))
    else $error("Beacon send flag disagrees with its cause.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second word was accepted while one is in work.");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("Configuration port not ready.");

endmodule

bind speed_turn_beacon_scheduler_top stbs_chk u_stbs_chk (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the speed and turn beacon scheduler.
// It drives position fixes and APB register writes, predicts every report word
// and compares it field by field; it depends on stbs_pkg and the RTL top level.
module testbench;
  import stbs_pkg::*;

  typedef struct packed {
    logic        fix_valid;
    logic        button_pressed;
    logic [15:0] speed_q4;
    logic [8:0]  course_deg;
    logic [31:0] now_ms;
  } fix_t;

  typedef struct packed {
    logic        manual_send;
    logic        beacon_send;
    logic [1:0]  beacon_cause;
    logic [31:0] interval_ms;
    logic [15:0] turn_limit_deg;
  } report_t;

  localparam int STUCK_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_fix_valid = 1'b0;
  logic in_button_pressed = 1'b0;
  logic [15:0] in_speed_q4 = '0;
  logic [8:0] in_course_deg = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_manual_send;
  logic out_beacon_send;
  logic [1:0] out_beacon_cause;
  logic [31:0] out_interval_ms;
  logic [15:0] out_turn_limit_deg;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  cfg_t sched_cfg;
  logic [8:0] prev_course;
  logic [31:0] last_beacon_ms;
  report_t pending_reports[$];
  report_t head_report;
  int errors = 0;
  int stall_pct = 0;
  int stall_run = 0;
  logic stall_now = 1'b0;
  int stuck_cycles = 0;
  int unsigned gen_course = 0;
  logic [31:0] gen_clock = '0;

  speed_turn_beacon_scheduler_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_fix_valid(in_fix_valid),
    .in_button_pressed(in_button_pressed),
    .in_speed_q4(in_speed_q4),
    .in_course_deg(in_course_deg),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_manual_send(out_manual_send),
    .out_beacon_send(out_beacon_send),
    .out_beacon_cause(out_beacon_cause),
    .out_interval_ms(out_interval_ms),
    .out_turn_limit_deg(out_turn_limit_deg),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic report_t schedule_fix(fix_t f);
    report_t r;
    logic [63:0] wide;
    logic [31:0] elapsed;
    int unsigned q, ivl, lim, delta;
    logic [1:0] cause;
    r = '0;
    if (!f.fix_valid) begin
      return r;
    end
    q = 32'(f.speed_q4);
    if (q < 32'(sched_cfg.low_speed_kmph) * 16) begin
      ivl = 32'(sched_cfg.slow_rate_s) * 1000;
    end else if (q > 32'(sched_cfg.high_speed_kmph) * 16) begin
      ivl = 32'(sched_cfg.fast_rate_s) * 1000;
    end else if (q == 0) begin
      ivl = 32'hFFFF_FFFF;
    end else begin
      wide = 64'(sched_cfg.fast_rate_s) * 64'(sched_cfg.high_speed_kmph) * 64'd16000 / 64'(q);
      ivl = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    end
    if (q == 0) begin
      lim = 65535;
    end else begin
      lim = 32'(sched_cfg.turn_min_deg) + (32'(sched_cfg.turn_gain) * 16) / q;
      if (lim > 65535) begin
        lim = 65535;
      end
    end
    delta = (32'(prev_course) > 32'(f.course_deg)) ? 32'(prev_course) - 32'(f.course_deg)
                                                   : 32'(f.course_deg) - 32'(prev_course);
    if (delta > 180) begin
      delta = (delta > 360) ? delta - 360 : 360 - delta;
    end
    cause = CAUSE_NONE;
    elapsed = f.now_ms - last_beacon_ms;
    if (delta > lim && elapsed > 32'(sched_cfg.min_turn_time_s) * 1000) begin
      cause = CAUSE_TURN;
      last_beacon_ms = f.now_ms;
    end
    prev_course = f.course_deg;
    elapsed = f.now_ms - last_beacon_ms;
    if (cause == CAUSE_NONE && elapsed > ivl) begin
      cause = CAUSE_INTERVAL;
      last_beacon_ms = f.now_ms;
    end
    r.manual_send = f.button_pressed;
    r.beacon_send = (cause != CAUSE_NONE);
    r.beacon_cause = cause;
    r.interval_ms = ivl;
    r.turn_limit_deg = lim[15:0];
    return r;
  endfunction

  function automatic fix_t make_fix(logic v, logic b, logic [15:0] s, logic [8:0] c,
                                    logic [31:0] n);
    fix_t f;
    f.fix_valid = v;
    f.button_pressed = b;
    f.speed_q4 = s;
    f.course_deg = c;
    f.now_ms = n;
    return f;
  endfunction

  function automatic fix_t random_fix();
    fix_t f;
    int roll;
    f.fix_valid = ($urandom_range(0, 99) >= 6);
    f.button_pressed = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 4) begin
      gen_clock = $urandom;
    end else begin
      gen_clock = gen_clock + $urandom_range(100, 4000);
    end
    f.now_ms = gen_clock;
    roll = $urandom_range(0, 9);
    case (roll)
      0: f.speed_q4 = '0;
      1: f.speed_q4 = 16'(32'(sched_cfg.low_speed_kmph) * 16 + $urandom_range(0, 2) - 1);
      2: f.speed_q4 = 16'(32'(sched_cfg.high_speed_kmph) * 16 + $urandom_range(0, 2) - 1);
      3: f.speed_q4 = 16'($urandom);
      default: f.speed_q4 = 16'($urandom_range(0, 4095));
    endcase
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      f.course_deg = 9'($urandom_range(360, 511));
    end else begin
      if (roll < 4) begin
        gen_course = $urandom_range(0, 359);
      end else begin
        gen_course = (gen_course + $urandom_range(0, 60) + 330) % 360;
      end
      f.course_deg = 9'(gen_course);
    end
    if (!f.fix_valid) begin
      f.speed_q4 = 16'($urandom);
      f.course_deg = 9'($urandom);
      f.now_ms = $urandom;
    end
    return f;
  endfunction

  function automatic cfg_t random_settings(bit lively);
    cfg_t c;
    c = cfg_t'({$urandom, $urandom, $urandom});
    if (lively) begin
      c.low_speed_kmph = 8'($urandom_range(0, 40));
      c.high_speed_kmph = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(40, 255));
      c.slow_rate_s = 16'($urandom_range(1, 8));
      c.fast_rate_s = 16'($urandom_range(0, 4));
      c.turn_min_deg = 8'($urandom_range(0, 180));
      c.turn_gain = 16'($urandom_range(0, 4000));
      c.min_turn_time_s = 16'($urandom_range(0, 6));
    end
    return c;
  endfunction

  task automatic send_fix(fix_t f);
    @(negedge clk);
    in_valid <= 1'b1;
    in_fix_valid <= f.fix_valid;
    in_button_pressed <= f.button_pressed;
    in_speed_q4 <= f.speed_q4;
    in_course_deg <= f.course_deg;
    in_now_ms <= f.now_ms;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(schedule_fix(f));
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LOW_SPEED: sched_cfg.low_speed_kmph = value[7:0];
      REG_HIGH_SPEED: sched_cfg.high_speed_kmph = value[7:0];
      REG_SLOW_RATE: sched_cfg.slow_rate_s = value[15:0];
      REG_FAST_RATE: sched_cfg.fast_rate_s = value[15:0];
      REG_TURN_MIN: sched_cfg.turn_min_deg = value[7:0];
      REG_TURN_GAIN: sched_cfg.turn_gain = value[15:0];
      REG_MIN_TURN_TIME: sched_cfg.min_turn_time_s = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t c);
    wait_drained();
    write_register(REG_LOW_SPEED, 32'(c.low_speed_kmph));
    write_register(REG_HIGH_SPEED, 32'(c.high_speed_kmph));
    write_register(REG_SLOW_RATE, 32'(c.slow_rate_s));
    write_register(REG_FAST_RATE, 32'(c.fast_rate_s));
    write_register(REG_TURN_MIN, 32'(c.turn_min_deg));
    write_register(REG_TURN_GAIN, 32'(c.turn_gain));
    write_register(REG_MIN_TURN_TIME, 32'(c.min_turn_time_s));
  endtask

  task automatic test_reset_defaults();
    stall_pct = 30;
    send_fix(make_fix(1'b0, 1'b1, 16'hFFFF, 9'd511, 32'hFFFF_FFFF));
    send_fix(make_fix(1'b1, 1'b1, 16'd0, 9'd0, 32'd1000));
    send_fix(make_fix(1'b1, 1'b0, 16'hFFFF, 9'd90, 32'd20000));
    send_fix(make_fix(1'b1, 1'b1, 16'd800, 9'd359, 32'd22000));
    send_fix(make_fix(1'b1, 1'b0, 16'd800, 9'd0, 32'd200000));
    send_fix(make_fix(1'b1, 1'b0, 16'd1600, 9'd511, 32'd200500));
    send_fix(make_fix(1'b1, 1'b0, 16'd159, 9'd400, 32'h0000_0100));
    send_fix(make_fix(1'b1, 1'b1, 16'd1601, 9'd180, 32'hFFFF_FFFF));
    send_fix(make_fix(1'b1, 1'b0, 16'd160, 9'd0, 32'h0000_0000));
  endtask

  task automatic test_zero_speed_mid_band();
    cfg_t c;
    c = '{low_speed_kmph: 8'd0, high_speed_kmph: 8'd100, slow_rate_s: 16'd1200,
          fast_rate_s: 16'd60, turn_min_deg: 8'd25, turn_gain: 16'd255,
          min_turn_time_s: 16'd15};
    apply_settings(c);
    send_fix(make_fix(1'b1, 1'b0, 16'd0, 9'd10, 32'h8000_0000));
    send_fix(make_fix(1'b1, 1'b1, 16'd0, 9'd200, 32'h8000_1000));
    c = '{low_speed_kmph: 8'd0, high_speed_kmph: 8'd255, slow_rate_s: 16'd0,
          fast_rate_s: 16'hFFFF, turn_min_deg: 8'd255, turn_gain: 16'hFFFF,
          min_turn_time_s: 16'd0};
    apply_settings(c);
    send_fix(make_fix(1'b1, 1'b0, 16'd1, 9'd20, 32'h8000_2000));
    send_fix(make_fix(1'b1, 1'b0, 16'd0, 9'd300, 32'h8000_3000));
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    stall_pct = 0;
    c = '1;
    apply_settings(c);
    send_fix(make_fix(1'b1, 1'b0, 16'd4079, 9'd180, 32'd1000));
    send_fix(make_fix(1'b1, 1'b1, 16'd4080, 9'd0, 32'd70000000));
    send_fix(make_fix(1'b1, 1'b0, 16'd4081, 9'd359, 32'd140000000));
    send_fix(make_fix(1'b1, 1'b0, 16'hFFFF, 9'd179, 32'hFFFF_FFFF));
    c = '0;
    apply_settings(c);
    send_fix(make_fix(1'b1, 1'b0, 16'd0, 9'd179, 32'hFFFF_FFFF));
    send_fix(make_fix(1'b1, 1'b0, 16'd1, 9'd179, 32'hFFFF_FFFF));
    send_fix(make_fix(1'b1, 1'b1, 16'd1, 9'd180, 32'h0000_0000));
    send_fix(make_fix(1'b1, 1'b0, 16'hFFFF, 9'd181, 32'h0000_0001));
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int phase = 0; phase < 4; phase++) begin
      apply_settings(random_settings(phase != 3));
      stall_pct = (phase == 1) ? 0 : $urandom_range(10, 60);
      sent = 0;
      while (sent < 150) begin
        burst = $urandom_range(1, 10);
        for (int k = 0; k < burst && sent < 150; k++) begin
          send_fix(random_fix());
          sent++;
          if (phase == 2 && sent == 75) begin
            wait_drained();
          end
        end
        if (phase != 1 && $urandom_range(0, 3) != 0) begin
          idle_gap($urandom_range(1, 60));
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_now = ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(1, 12);
    end
    stall_run--;
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report word with no fix pending");
        errors++;
      end else begin
        head_report = pending_reports.pop_front();
        check_field("manual_send", 32'(head_report.manual_send), 32'(out_manual_send));
        check_field("beacon_send", 32'(head_report.beacon_send), 32'(out_beacon_send));
        check_field("beacon_cause", 32'(head_report.beacon_cause), 32'(out_beacon_cause));
        check_field("interval_ms", head_report.interval_ms, out_interval_ms);
        check_field("turn_limit_deg", 32'(head_report.turn_limit_deg),
                    32'(out_turn_limit_deg));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    sched_cfg = '{low_speed_kmph: 8'd10, high_speed_kmph: 8'd100, slow_rate_s: 16'd1200,
                  fast_rate_s: 16'd60, turn_min_deg: 8'd25, turn_gain: 16'd255,
                  min_turn_time_s: 16'd15};
    prev_course = '0;
    last_beacon_ms = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_speed_mid_band();
    test_register_extremes();
    test_random_traffic();
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
